// File: hw/rtl/lfsa_pkg.sv
`default_nettype none

package lfsa_pkg;

    localparam int unsigned STAMP_W = 32;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_TOUCH   = 2'd1,
        ACT_CLAIM   = 2'd2,
        ACT_RELEASE = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_GRANT,
        ST_OP_RD,
        ST_OP_WR
    } t_state;

endpackage

`default_nettype wire

// File: hw/rtl/lru_free_slot_allocator_top.sv
`default_nettype none
// least-recently-used free slot allocator
//
// input channel: an item (i_action, i_group, i_slot) is taken at a rising edge
// with start high and busy low. busy stays high while the item is worked on.
// result channel: o_granted_slot and o_accepted are valid for exactly one
// cycle with o_strobe high; the receiver cannot stall, so results are never
// held back and nothing waits on the output side.
// allocate reads the group's SLOTS entries through the single
// stamp memory read port, one per cycle, then grants the free entry with
// the smallest stamp. touch, claim and release do one read and one write
// of the entry. an out-of-range item is answered directly from idle.
// items are taken one at a time: a new one waits until busy is low.
// reset: the stamp memory (stamp and taken bit per entry) is cleared by a
// pass over all GROUPS*SLOTS entries, one entry per cycle, with busy high;
// the tick counter is zeroed at once.
module lru_free_slot_allocator_top
    import lfsa_pkg::*;
#(
    parameter int unsigned GROUPS = 8,
    parameter int unsigned SLOTS  = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] i_action,
    input  wire logic [3:0] i_group,
    input  wire logic [5:0] i_slot,
    output logic            o_strobe,
    output logic [5:0]      o_granted_slot,
    output logic            o_accepted
);

    localparam int unsigned ENTRIES = GROUPS * SLOTS;
    localparam int unsigned AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned IW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned DW      = STAMP_W + 1;
    localparam logic [STAMP_W-1:0] TICK_MAX = {STAMP_W{1'b1}};

    logic [DW-1:0] r_mem [ENTRIES];
    logic [DW-1:0] r_rdata;

    t_state r_state, n_state;
    t_action r_action, n_action;
    logic [AW-1:0] r_addr, n_addr;
    logic [AW-1:0] r_clr, n_clr;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_chk_idx, n_chk_idx;
    logic r_chk, n_chk;
    logic r_found, n_found;
    logic [IW-1:0] r_best_idx, n_best_idx;
    logic [STAMP_W-1:0] r_best_stamp, n_best_stamp;
    logic [STAMP_W-1:0] r_tick, n_tick;
    logic r_strobe, n_strobe;
    logic [5:0] r_granted, n_granted;
    logic r_accepted, n_accepted;

    logic w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [DW-1:0] w_wdata;
    logic [STAMP_W-1:0] w_tick_inc;
    logic w_better;
    logic w_group_ok, w_slot_ok;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    assign w_tick_inc = (r_tick == TICK_MAX) ? r_tick : r_tick + 1'b1;
    assign w_group_ok = (32'(i_group) < GROUPS);
    assign w_slot_ok  = (i_slot != 6'd0) && (32'(i_slot) <= SLOTS);

    // shared compare: free entry with strictly smaller stamp wins
    assign w_better = r_chk && !r_rdata[STAMP_W]
                      && (!r_found || (r_rdata[STAMP_W-1:0] < r_best_stamp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr      <= '0;
            r_tick     <= '0;
            r_strobe   <= 1'b0;
            r_chk      <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_tick     <= n_tick;
            r_strobe   <= n_strobe;
            r_chk      <= n_chk;
            r_found    <= n_found;
        end
        r_action     <= n_action;
        r_addr       <= n_addr;
        r_idx        <= n_idx;
        r_chk_idx    <= n_chk_idx;
        r_best_idx   <= n_best_idx;
        r_best_stamp <= n_best_stamp;
        r_granted    <= n_granted;
        r_accepted   <= n_accepted;
    end

    always_comb begin
        n_state      = r_state;
        n_action     = r_action;
        n_addr       = r_addr;
        n_clr        = r_clr;
        n_idx        = r_idx;
        n_chk_idx    = r_idx;
        n_chk        = 1'b0;
        n_found      = r_found;
        n_best_idx   = r_best_idx;
        n_best_stamp = r_best_stamp;
        n_tick       = r_tick;
        n_strobe     = 1'b0;
        n_granted    = r_granted;
        n_accepted   = r_accepted;
        w_we         = 1'b0;
        w_waddr      = r_addr;
        w_wdata      = '0;
        w_raddr      = r_addr;

        if (w_better) begin
            n_found      = 1'b1;
            n_best_idx   = r_chk_idx;
            n_best_stamp = r_rdata[STAMP_W-1:0];
        end

        case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                n_clr   = r_clr + 1'b1;
                if (r_clr == AW'(ENTRIES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_action = t_action'(i_action);
                    n_idx    = '0;
                    n_found  = 1'b0;
                    if (!w_group_ok) begin
                        n_strobe   = 1'b1;
                        n_granted  = 6'd0;
                        n_accepted = 1'b0;
                    end else if (t_action'(i_action) == ACT_ALLOC) begin
                        n_addr  = AW'(32'(i_group) * SLOTS);
                        n_state = ST_SCAN;
                    end else if (w_slot_ok) begin
                        n_addr  = AW'(32'(i_group) * SLOTS + 32'(i_slot) - 32'd1);
                        n_state = ST_OP_RD;
                    end else begin
                        n_strobe   = 1'b1;
                        n_granted  = 6'd0;
                        n_accepted = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                w_raddr = r_addr + AW'(r_idx);
                n_chk   = 1'b1;
                n_idx   = r_idx + 1'b1;
                if (r_idx == IW'(SLOTS - 1)) begin
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                n_state = ST_GRANT;
            end
            ST_GRANT: begin
                n_state  = ST_IDLE;
                n_strobe = 1'b1;
                if (r_found) begin
                    w_we       = 1'b1;
                    w_waddr    = r_addr + AW'(r_best_idx);
                    w_wdata    = {1'b0, w_tick_inc};
                    n_tick     = w_tick_inc;
                    n_granted  = 6'(r_best_idx) + 6'd1;
                    n_accepted = 1'b1;
                end else begin
                    n_granted  = 6'd0;
                    n_accepted = 1'b0;
                end
            end
            ST_OP_RD: begin
                n_state = ST_OP_WR;
            end
            ST_OP_WR: begin
                n_state    = ST_IDLE;
                n_strobe   = 1'b1;
                n_granted  = 6'd0;
                n_accepted = 1'b1;
                w_we       = 1'b1;
                case (r_action)
                    ACT_CLAIM: begin
                        w_wdata = {1'b1, r_rdata[STAMP_W-1:0]};
                    end
                    ACT_RELEASE: begin
                        w_wdata = {1'b0, w_tick_inc};
                        n_tick  = w_tick_inc;
                    end
                    default: begin
                        w_wdata = {r_rdata[STAMP_W], w_tick_inc};
                        n_tick  = w_tick_inc;
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_strobe       = r_strobe;
    assign o_granted_slot = r_granted;
    assign o_accepted     = r_accepted;

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top
    import lfsa_pkg::*;
();

    localparam int unsigned GROUPS_N  = 8;
    localparam int unsigned SLOTS_N   = 32;
    localparam int unsigned ENTRIES_N = GROUPS_N * SLOTS_N;
    localparam int          NUM_ITEMS = 800;
    localparam int          NUM_DIR   = 25;
    localparam int          LIMIT     = 500000;

    typedef struct packed {
        logic [5:0] granted;
        logic       accepted;
    } t_grant;

    typedef struct packed {
        t_action    act;
        logic [3:0] grp;
        logic [5:0] slt;
        logic       typed;
        logic [5:0] granted;
        logic       accepted;
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [1:0] i_action;
    logic [3:0] i_group;
    logic [5:0] i_slot;
    logic       o_strobe;
    logic [5:0] o_granted_slot;
    logic       o_accepted;

    lru_free_slot_allocator_top #(
        .GROUPS(GROUPS_N),
        .SLOTS (SLOTS_N)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_group       (i_group),
        .i_slot        (i_slot),
        .o_strobe      (o_strobe),
        .o_granted_slot(o_granted_slot),
        .o_accepted    (o_accepted)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the slot table
    logic [31:0] stamp_mem [ENTRIES_N];
    logic        taken_mem [ENTRIES_N];
    logic [31:0] tick_now;

    t_grant      pending_grants[$];
    t_grant      oldest_grant;
    t_dir_row    dir_rows [NUM_DIR];
    int          errors       = 0;
    int          checked      = 0;
    int          cycles       = 0;
    int          rand_count   = 0;
    int          full_allocs  = 0;
    bit          allow_idle   = 1'b0;
    bit          drained      = 1'b0;

    function automatic void stamp_slot(input int unsigned idx);
        if (tick_now != 32'hFFFF_FFFF)
            tick_now = tick_now + 32'd1;
        stamp_mem[idx] = tick_now;
    endfunction

    function automatic t_grant lru_predict(input t_action act, input logic [3:0] grp,
                                           input logic [5:0] slt);
        t_grant      r;
        int unsigned best;
        int unsigned base;
        int unsigned idx;
        r    = '0;
        best = 0;
        base = int'(grp) * SLOTS_N;
        if (int'(grp) < GROUPS_N) begin
            if (act == ACT_ALLOC) begin
                for (int unsigned n = 1; n <= SLOTS_N; n++) begin
                    idx = base + n - 1;
                    if (!taken_mem[idx] &&
                        (best == 0 || stamp_mem[idx] < stamp_mem[base + best - 1]))
                        best = n;
                end
                if (best != 0) begin
                    stamp_slot(base + best - 1);
                    r.granted  = best[5:0];
                    r.accepted = 1'b1;
                end else begin
                    full_allocs++;
                end
            end else if (slt >= 6'd1 && int'(slt) <= SLOTS_N) begin
                idx = base + int'(slt) - 1;
                case (act)
                    ACT_TOUCH: begin
                        stamp_slot(idx);
                    end
                    ACT_CLAIM: begin
                        taken_mem[idx] = 1'b1;
                    end
                    default: begin
                        stamp_slot(idx);
                        taken_mem[idx] = 1'b0;
                    end
                endcase
                r.accepted = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic send_item(input t_action act, input logic [3:0] grp, input logic [5:0] slt,
                             input bit use_typed, input t_grant typed_res);
        t_grant pred;
        int     gap;
        gap = 0;
        // no idling in every third stretch of 40 items
        if (allow_idle && ((rand_count / 40) % 3 != 0) && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 9);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_action <= act;
        i_group  <= grp;
        i_slot   <= slt;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pred = lru_predict(act, grp, slt);
        pending_grants.push_back(use_typed ? typed_res : pred);
        if (int'(grp) < GROUPS_N)
            rand_count++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_grants.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_grants.size() == 0) begin
                errors++;
                $display("%0t: unexpected result granted_slot=%0d accepted=%0d",
                         $time, o_granted_slot, o_accepted);
            end else begin
                oldest_grant = pending_grants.pop_front();
                checked++;
                if (o_granted_slot !== oldest_grant.granted) begin
                    errors++;
                    $display("%0t: granted_slot expected %0d actual %0d",
                             $time, oldest_grant.granted, o_granted_slot);
                end
                if (o_accepted !== oldest_grant.accepted) begin
                    errors++;
                    $display("%0t: accepted expected %0d actual %0d",
                             $time, oldest_grant.accepted, o_accepted);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_grants.size());
            $display("FAIL");
            $finish;
        end
    end

    int          kind;
    int          order [SLOTS_N];
    int          tmp;
    int          pick;
    int          nrel;
    logic [3:0]  fgrp;
    int          dir_total;

    initial begin
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_action = '0;
        i_group  = '0;
        i_slot   = '0;
        tick_now = '0;
        for (int k = 0; k < ENTRIES_N; k++) begin
            stamp_mem[k] = '0;
            taken_mem[k] = 1'b0;
        end

        dir_rows = '{
            '{ACT_ALLOC,   4'd0,  6'd0,  1'b1, 6'd1, 1'b1},
            '{ACT_ALLOC,   4'd0,  6'd63, 1'b1, 6'd2, 1'b1},
            '{ACT_ALLOC,   4'd7,  6'd0,  1'b1, 6'd1, 1'b1},
            '{ACT_ALLOC,   4'd8,  6'd0,  1'b1, 6'd0, 1'b0},
            '{ACT_ALLOC,   4'd15, 6'd63, 1'b1, 6'd0, 1'b0},
            '{ACT_TOUCH,   4'd0,  6'd0,  1'b1, 6'd0, 1'b0},
            '{ACT_TOUCH,   4'd0,  6'd33, 1'b1, 6'd0, 1'b0},
            '{ACT_CLAIM,   4'd0,  6'd63, 1'b1, 6'd0, 1'b0},
            '{ACT_RELEASE, 4'd15, 6'd1,  1'b1, 6'd0, 1'b0},
            '{ACT_CLAIM,   4'd0,  6'd3,  1'b1, 6'd0, 1'b1},
            '{ACT_CLAIM,   4'd0,  6'd3,  1'b1, 6'd0, 1'b1},
            '{ACT_ALLOC,   4'd0,  6'd0,  1'b1, 6'd4, 1'b1},
            '{ACT_RELEASE, 4'd0,  6'd32, 1'b1, 6'd0, 1'b1},
            '{ACT_TOUCH,   4'd0,  6'd1,  1'b1, 6'd0, 1'b1},
            '{ACT_RELEASE, 4'd0,  6'd3,  1'b1, 6'd0, 1'b1},
            '{ACT_ALLOC,   4'd0,  6'd0,  1'b0, 6'd0, 1'b0},
            '{ACT_CLAIM,   4'd7,  6'd32, 1'b1, 6'd0, 1'b1},
            '{ACT_TOUCH,   4'd7,  6'd32, 1'b1, 6'd0, 1'b1},
            '{ACT_ALLOC,   4'd7,  6'd0,  1'b0, 6'd0, 1'b0},
            '{ACT_TOUCH,   4'd9,  6'd32, 1'b1, 6'd0, 1'b0},
            '{ACT_ALLOC,   4'd1,  6'd0,  1'b1, 6'd1, 1'b1},
            '{ACT_ALLOC,   4'd6,  6'd0,  1'b0, 6'd0, 1'b0},
            '{ACT_RELEASE, 4'd2,  6'd63, 1'b1, 6'd0, 1'b0},
            '{ACT_TOUCH,   4'd4,  6'd16, 1'b1, 6'd0, 1'b1},
            '{ACT_CLAIM,   4'd0,  6'd32, 1'b1, 6'd0, 1'b1}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < NUM_DIR; k++)
            send_item(dir_rows[k].act, dir_rows[k].grp, dir_rows[k].slt, dir_rows[k].typed,
                      {dir_rows[k].granted, dir_rows[k].accepted});
        drain_results();
        dir_total  = NUM_DIR;
        rand_count = 0;
        allow_idle = 1'b1;

        while (rand_count < NUM_ITEMS) begin
            if (!drained && rand_count >= NUM_ITEMS / 2) begin
                drain_results();
                drained = 1'b1;
            end
            if (rand_count >= NUM_ITEMS - 100)
                allow_idle = 1'b0;
            kind = $urandom_range(0, 11);
            if (kind == 0) begin
                // fill one group completely, then allocate against it
                fgrp = 4'($urandom_range(0, GROUPS_N - 1));
                for (int k = 0; k < SLOTS_N; k++)
                    order[k] = k + 1;
                for (int k = SLOTS_N - 1; k > 0; k--) begin
                    pick        = $urandom_range(0, k);
                    tmp         = order[k];
                    order[k]    = order[pick];
                    order[pick] = tmp;
                end
                for (int k = 0; k < SLOTS_N; k++)
                    send_item(ACT_CLAIM, fgrp, 6'(order[k]), 1'b0, '0);
                send_item(ACT_ALLOC, fgrp, 6'($urandom_range(0, 63)), 1'b0, '0);
                nrel = $urandom_range(1, 3);
                for (int k = 0; k < nrel; k++)
                    send_item(ACT_RELEASE, fgrp, 6'($urandom_range(1, SLOTS_N)), 1'b0, '0);
                for (int k = 0; k <= nrel; k++)
                    send_item(ACT_ALLOC, fgrp, 6'($urandom_range(0, 63)), 1'b0, '0);
            end else if (kind == 1) begin
                send_item(t_action'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                          6'($urandom_range(0, 63)), 1'b0, '0);
            end else begin
                send_item(t_action'($urandom_range(0, 3)),
                          4'($urandom_range(0, GROUPS_N - 1)),
                          ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                      : 6'($urandom_range(1, SLOTS_N)),
                          1'b0, '0);
            end
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (SLOTS_N + 8) @(posedge i_clk);

        $display("run: %0d directed and %0d random items in range, %0d results checked",
                 dir_total, rand_count, checked);
        $display("run: %0d allocates hit a full group, final tick %0d", full_allocs, tick_now);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
